### sv/rpn_stack_evaluator_assert.svh
// Assertion macros for the RPN stack evaluator.
// No dependencies; included by the top level after its datapath.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication.
`define RPN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RPN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rpn_pkg.sv
// Shared types, constants and the microcode ROM of the RPN stack evaluator.
// No dependencies.
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int HGT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = 5;

    localparam logic [7:0] SYM_EQUALS = 8'h3D;
    localparam logic [7:0] SYM_SPACE  = 8'h20;
    localparam logic [7:0] SYM_PLUS   = 8'h2B;
    localparam logic [7:0] SYM_MINUS  = 8'h2D;
    localparam logic [7:0] SYM_TIMES  = 8'h2A;
    localparam logic [7:0] SYM_DIVIDE = 8'h2F;
    localparam logic [7:0] SYM_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        A_NONE,
        A_TAKE,
        A_CLEAR,
        A_LD_RIGHT,
        A_LD_LEFT,
        A_ALU,
        A_DIV_GO,
        A_LD_QUO,
        A_WR_RES,
        A_PUSH_DIG,
        A_EMIT_VAL,
        A_EMIT_ERR,
        A_FAIL
    } t_act;

    // Jump condition; the jump is taken when it holds, else fall through.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_FAILED,
        C_NOT_EQ,
        C_SPACE,
        C_NOT_OP,
        C_HEIGHT_ZERO,
        C_HEIGHT_LT2,
        C_FULL,
        C_IS_DIV,
        C_RIGHT_ZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_act    act;
        t_cond   cond;
        logic    rd_next;   // read address: 0 top, 1 entry below top
        t_status status;
        t_step   target;
    } t_cw;

    typedef struct packed {
        logic no_input;
        logic failed;
        logic not_eq;
        logic space;
        logic not_op;
        logic height_zero;
        logic height_lt2;
        logic full;
        logic is_div;
        logic right_zero;
        logic div_busy;
        logic out_busy;
    } t_flags;

    // Program labels
    localparam t_step L_IDLE     = 5'd0;
    localparam t_step L_EQ_WAIT  = 5'd4;
    localparam t_step L_EQ_EMPTY = 5'd6;
    localparam t_step L_CLEAR    = 5'd8;
    localparam t_step L_NOT_EQ   = 5'd9;
    localparam t_step L_WR_RES   = 5'd16;
    localparam t_step L_DIV      = 5'd17;
    localparam t_step L_DIV_WAIT = 5'd19;
    localparam t_step L_DIGIT    = 5'd21;
    localparam t_step L_UNDER    = 5'd23;
    localparam t_step L_OVF      = 5'd25;
    localparam t_step L_DZ       = 5'd27;

    function automatic t_cw f_word(input t_act act, input t_cond cond, input logic rd_next,
                                   input t_status status, input t_step target);
        t_cw w;
        w.act     = act;
        w.cond    = cond;
        w.rd_next = rd_next;
        w.status  = status;
        w.target  = target;
        return w;
    endfunction

    function automatic t_cw f_ucode(input t_step step);
        t_cw w;
        unique case (step)
            // wait for a symbol
            5'd0:  w = f_word(A_TAKE,     C_NO_INPUT,    1'b0, ST_OK,        L_IDLE);
            5'd1:  w = f_word(A_NONE,     C_NOT_EQ,      1'b0, ST_OK,        L_NOT_EQ);
            // equals sign
            5'd2:  w = f_word(A_NONE,     C_FAILED,      1'b0, ST_OK,        L_CLEAR);
            5'd3:  w = f_word(A_NONE,     C_HEIGHT_ZERO, 1'b0, ST_OK,        L_EQ_EMPTY);
            5'd4:  w = f_word(A_NONE,     C_OUT_BUSY,    1'b0, ST_OK,        L_EQ_WAIT);
            5'd5:  w = f_word(A_EMIT_VAL, C_ALWAYS,      1'b0, ST_OK,        L_IDLE);
            5'd6:  w = f_word(A_NONE,     C_OUT_BUSY,    1'b0, ST_OK,        L_EQ_EMPTY);
            5'd7:  w = f_word(A_EMIT_ERR, C_ALWAYS,      1'b0, ST_UNDERFLOW, L_IDLE);
            5'd8:  w = f_word(A_CLEAR,    C_ALWAYS,      1'b0, ST_OK,        L_IDLE);
            // everything else
            5'd9:  w = f_word(A_NONE,     C_FAILED,      1'b0, ST_OK,        L_IDLE);
            5'd10: w = f_word(A_NONE,     C_SPACE,       1'b0, ST_OK,        L_IDLE);
            5'd11: w = f_word(A_NONE,     C_NOT_OP,      1'b0, ST_OK,        L_DIGIT);
            5'd12: w = f_word(A_NONE,     C_HEIGHT_LT2,  1'b0, ST_OK,        L_UNDER);
            5'd13: w = f_word(A_LD_RIGHT, C_NEVER,       1'b1, ST_OK,        L_IDLE);
            5'd14: w = f_word(A_LD_LEFT,  C_IS_DIV,      1'b0, ST_OK,        L_DIV);
            5'd15: w = f_word(A_ALU,      C_NEVER,       1'b0, ST_OK,        L_IDLE);
            5'd16: w = f_word(A_WR_RES,   C_ALWAYS,      1'b0, ST_OK,        L_IDLE);
            5'd17: w = f_word(A_NONE,     C_RIGHT_ZERO,  1'b0, ST_OK,        L_DZ);
            5'd18: w = f_word(A_DIV_GO,   C_NEVER,       1'b0, ST_OK,        L_IDLE);
            5'd19: w = f_word(A_NONE,     C_DIV_BUSY,    1'b0, ST_OK,        L_DIV_WAIT);
            5'd20: w = f_word(A_LD_QUO,   C_ALWAYS,      1'b0, ST_OK,        L_WR_RES);
            5'd21: w = f_word(A_NONE,     C_FULL,        1'b0, ST_OK,        L_OVF);
            5'd22: w = f_word(A_PUSH_DIG, C_ALWAYS,      1'b0, ST_OK,        L_IDLE);
            // error reports
            5'd23: w = f_word(A_NONE,     C_OUT_BUSY,    1'b0, ST_OK,        L_UNDER);
            5'd24: w = f_word(A_FAIL,     C_ALWAYS,      1'b0, ST_UNDERFLOW, L_IDLE);
            5'd25: w = f_word(A_NONE,     C_OUT_BUSY,    1'b0, ST_OK,        L_OVF);
            5'd26: w = f_word(A_FAIL,     C_ALWAYS,      1'b0, ST_OVERFLOW,  L_IDLE);
            5'd27: w = f_word(A_NONE,     C_OUT_BUSY,    1'b0, ST_OK,        L_DZ);
            5'd28: w = f_word(A_FAIL,     C_ALWAYS,      1'b0, ST_DIVZERO,   L_IDLE);
            default: w = f_word(A_NONE,   C_ALWAYS,      1'b0, ST_OK,        L_IDLE);
        endcase
        return w;
    endfunction

endpackage

### sv/rpn_if.sv
// Valid/ready channel interfaces: symbol input and result output.
// Depends on rpn_pkg.
`timescale 1ns / 1ps

interface rpn_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface rpn_res_if;
    import rpn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  value;
    t_status                   status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

### sv/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: operand stack memory, ALU, result register.
// Depends on rpn_pkg, rpn_if, rpn_div, rpn_seq and rpn_stack_evaluator_assert.svh.
//
//  channel | dir | payload                        | handshake
//  i_sym   | in  | symbol[7:0]                    | valid/ready, transfer when both high
//  o_res   | out | value[31:0] signed, status[1:0]| valid/ready, transfer when both high
//
// One symbol at a time; ready is high while the sequencer waits at its idle step.
// After an error, symbols other than equals are ignored.
// A result or report waits while the result register still holds an untaken result.
// Synchronous active-low reset clears height, error flag, output valid and step; the
// stack memory has no reset and needs no clearing pass.
`timescale 1ns / 1ps

module rpn_stack_evaluator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_sym_if.sink    i_sym,
    rpn_res_if.source  o_res
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [7:0]        r_sym,       n_sym;
    logic [HGT_W-1:0]  r_height,    n_height;
    logic              r_failed,    n_failed;
    logic [DATA_W-1:0] r_right,     n_right;
    logic [DATA_W-1:0] r_left,      n_left;
    logic [DATA_W-1:0] r_acc,       n_acc;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;
    logic [DATA_W-1:0] r_rd_data;

    t_cw               cw;
    t_flags            flags;
    logic              div_busy;
    logic [DATA_W-1:0] quotient;
    logic [HGT_W-1:0]  h_m1;
    logic [HGT_W-1:0]  h_m2;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              wr_en;
    logic [DATA_W-1:0] alu;
    logic              is_op;

    rpn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_cw    (cw)
    );

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (cw.act == A_DIV_GO),
        .i_dividend (r_left),
        .i_divisor  (r_right),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    assign is_op = (r_sym == SYM_PLUS) || (r_sym == SYM_MINUS) ||
                   (r_sym == SYM_TIMES) || (r_sym == SYM_DIVIDE);

    always_comb begin
        flags.no_input    = !i_sym.valid;
        flags.failed      = r_failed;
        flags.not_eq      = (r_sym != SYM_EQUALS);
        flags.space       = (r_sym == SYM_SPACE);
        flags.not_op      = !is_op;
        flags.height_zero = (r_height == '0);
        flags.height_lt2  = (r_height < HGT_W'(2));
        flags.full        = (r_height == HGT_W'(STACK_DEPTH));
        flags.is_div      = (r_sym == SYM_DIVIDE);
        flags.right_zero  = (r_right == '0);
        flags.div_busy    = div_busy;
        flags.out_busy    = r_out_valid && !o_res.ready;
    end

    // stack addressing: top is height-1, the left operand sits below it
    assign h_m1    = r_height - HGT_W'(1);
    assign h_m2    = r_height - HGT_W'(2);
    assign rd_addr = cw.rd_next ? h_m2[ADDR_W-1:0] : h_m1[ADDR_W-1:0];
    assign wr_en   = (cw.act == A_PUSH_DIG) || (cw.act == A_WR_RES);
    assign wr_addr = (cw.act == A_PUSH_DIG) ? r_height[ADDR_W-1:0] : h_m2[ADDR_W-1:0];
    assign wr_data = (cw.act == A_PUSH_DIG) ? (DATA_W'(r_sym) - DATA_W'(SYM_ZERO)) : r_acc;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        unique case (r_sym)
            SYM_PLUS:  alu = r_left + r_right;
            SYM_MINUS: alu = r_left - r_right;
            default:   alu = r_left * r_right;
        endcase
    end

    always_comb begin
        n_sym        = r_sym;
        n_height     = r_height;
        n_failed     = r_failed;
        n_right      = r_right;
        n_left       = r_left;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (cw.act)
            A_NONE, A_DIV_GO: begin
            end
            A_TAKE: begin
                if (i_sym.valid) begin
                    n_sym = i_sym.symbol;
                end
            end
            A_CLEAR: begin
                n_height = '0;
                n_failed = 1'b0;
            end
            A_LD_RIGHT: n_right = r_rd_data;
            A_LD_LEFT:  n_left  = r_rd_data;
            A_ALU:      n_acc   = alu;
            A_LD_QUO:   n_acc   = quotient;
            A_WR_RES:   n_height = r_height - HGT_W'(1);
            A_PUSH_DIG: n_height = r_height + HGT_W'(1);
            A_EMIT_VAL: begin
                n_out_valid  = 1'b1;
                n_out_value  = r_rd_data;
                n_out_status = ST_OK;
                n_height     = '0;
            end
            A_EMIT_ERR: begin
                n_out_valid  = 1'b1;
                n_out_value  = '0;
                n_out_status = cw.status;
            end
            A_FAIL: begin
                n_out_valid  = 1'b1;
                n_out_value  = '0;
                n_out_status = cw.status;
                n_failed     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_height    <= n_height;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_right      <= n_right;
        r_left       <= n_left;
        r_acc        <= n_acc;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign i_sym.ready  = (cw.act == A_TAKE);
    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

`include "rpn_stack_evaluator_assert.svh"

    `RPN_ASSERT_NOW(a_height_bound, i_clk, i_rst_n, 1'b1,
                    r_height <= HGT_W'(STACK_DEPTH), "stack height beyond depth")
    `RPN_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && (r_out_status != ST_OK),
                    r_out_value == '0, "error result carries a value")
    `RPN_ASSERT_NOW(a_idle_div, i_clk, i_rst_n, i_sym.ready,
                    !div_busy, "divider busy while accepting symbols")
    `RPN_ASSERT_NEXT(a_fail_sets, i_clk, i_rst_n, cw.act == A_FAIL,
                     r_failed && r_out_valid, "error report did not set failed state")

endmodule

### sv/rpn_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on rpn_pkg.
`timescale 1ns / 1ps

module rpn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rpn_pkg::DATA_W-1:0]  i_dividend,
    input  logic [rpn_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [rpn_pkg::DATA_W-1:0]  o_quotient
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;
    logic             r_neg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a   = i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
    assign mag_b   = i_divisor[DATA_W-1]  ? (DATA_W'(0) - i_divisor)  : i_divisor;
    assign shifted = {r_rem, r_quo[DATA_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_dvs <= mag_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            // restoring step: keep the difference when it did not go negative
            if (!diff[DATA_W]) begin
                r_rem <= diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

### sv/rpn_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on rpn_pkg.
`timescale 1ns / 1ps

module rpn_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpn_pkg::t_flags i_flags,
    output rpn_pkg::t_cw    o_cw
);
    import rpn_pkg::*;

    t_step r_step;
    t_step n_step;
    t_cw   cw;
    logic  jump;

    assign cw = f_ucode(r_step);

    always_comb begin
        unique case (cw.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_INPUT:    jump = i_flags.no_input;
            C_FAILED:      jump = i_flags.failed;
            C_NOT_EQ:      jump = i_flags.not_eq;
            C_SPACE:       jump = i_flags.space;
            C_NOT_OP:      jump = i_flags.not_op;
            C_HEIGHT_ZERO: jump = i_flags.height_zero;
            C_HEIGHT_LT2:  jump = i_flags.height_lt2;
            C_FULL:        jump = i_flags.full;
            C_IS_DIV:      jump = i_flags.is_div;
            C_RIGHT_ZERO:  jump = i_flags.right_zero;
            C_DIV_BUSY:    jump = i_flags.div_busy;
            C_OUT_BUSY:    jump = i_flags.out_busy;
            default:       jump = 1'b1;
        endcase
        n_step = jump ? cw.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= L_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_cw = cw;

endmodule

### dv/tb_top.sv
// Self-checking testbench for rpn_stack_evaluator: tracks the operand stack per symbol
// and checks every result transfer. Depends on rpn_pkg, rpn_if and the evaluator RTL.
`timescale 1ns / 1ps

import rpn_pkg::*;

typedef struct {
    logic signed [DATA_W-1:0] value;
    t_status                  status;
} calc_result_t;

// Tracks the evaluator state symbol by symbol and holds the results still owed.
class expression_tracker;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       height;
    bit                failed;
    calc_result_t      pending [$];
    int                mismatches;

    function new();
        height     = 0;
        failed     = 1'b0;
        mismatches = 0;
    endfunction

    function void await_result(logic [DATA_W-1:0] value, t_status status);
        calc_result_t r;
        r.value  = value;
        r.status = status;
        pending.push_back(r);
    endfunction

    function void note_symbol(logic [7:0] sym);
        logic [DATA_W-1:0]        lhs;
        logic [DATA_W-1:0]        rhs;
        logic [DATA_W-1:0]        res;
        logic signed [DATA_W-1:0] s_lhs;
        logic signed [DATA_W-1:0] s_rhs;
        if (sym == SYM_EQUALS) begin
            if (failed) begin
                failed = 1'b0;
                height = 0;
            end else if (height == 0) begin
                await_result('0, ST_UNDERFLOW);
            end else begin
                await_result(operands[height - 1], ST_OK);
                height = 0;
            end
            return;
        end
        if (failed || sym == SYM_SPACE)
            return;
        if (sym == SYM_PLUS || sym == SYM_MINUS || sym == SYM_TIMES || sym == SYM_DIVIDE) begin
            if (height < 2) begin
                failed = 1'b1;
                await_result('0, ST_UNDERFLOW);
                return;
            end
            rhs = operands[height - 1];
            lhs = operands[height - 2];
            case (sym)
                SYM_PLUS:  res = lhs + rhs;
                SYM_MINUS: res = lhs - rhs;
                SYM_TIMES: res = lhs * rhs;
                default: begin
                    if (rhs == '0) begin
                        failed = 1'b1;
                        await_result('0, ST_DIVZERO);
                        return;
                    end
                    s_lhs = lhs;
                    s_rhs = rhs;
                    // most negative / -1 wraps back to itself
                    if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF)
                        res = lhs;
                    else
                        res = s_lhs / s_rhs;
                end
            endcase
            height = height - 1;
            operands[height - 1] = res;
            return;
        end
        if (height >= STACK_DEPTH) begin
            failed = 1'b1;
            await_result('0, ST_OVERFLOW);
            return;
        end
        operands[height] = {24'd0, sym} - {24'd0, SYM_ZERO};
        height = height + 1;
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, t_status status);
        calc_result_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result value %0d status %0d", $realtime, value, status);
            return;
        end
        want = pending.pop_front();
        if (value !== want.value || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result mismatch: expected value %0d status %0d, got value %0d status %0d",
                         $realtime, want.value, want.status, value, status);
        end
    endfunction
endclass

module tb_top;
    logic i_clk;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   symbols_sent;

    rpn_sym_if sym_ch ();
    rpn_res_if res_ch ();

    expression_tracker tracker = new();

    rpn_stack_evaluator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sym   (sym_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL rpn_stack_evaluator");
        $finish;
    end

    // Result side: check each transfer, then pick the next ready level.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready)
                tracker.check_result(res_ch.value, res_ch.status);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_symbol(input logic [7:0] sym);
        while ($urandom_range(99) < idle_pct) begin
            sym_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sym_ch.valid  <= 1'b1;
        sym_ch.symbol <= sym;
        do
            @(posedge i_clk);
        while (!sym_ch.ready);
        tracker.note_symbol(sym);
        symbols_sent++;
    endtask

    function automatic logic [7:0] random_op();
        case ($urandom_range(3))
            0:       return SYM_PLUS;
            1:       return SYM_MINUS;
            2:       return SYM_TIMES;
            default: return SYM_DIVIDE;
        endcase
    endfunction

    // Mostly decimal digits; now and then any byte that pushes a value.
    function automatic logic [7:0] random_operand();
        logic [7:0] s;
        if ($urandom_range(99) < 85)
            return 8'(SYM_ZERO + $urandom_range(9));
        do
            s = 8'($urandom_range(255));
        while (s == SYM_EQUALS || s == SYM_SPACE || s == SYM_PLUS || s == SYM_MINUS ||
               s == SYM_TIMES || s == SYM_DIVIDE);
        return s;
    endfunction

    task automatic send_random_sequence();
        int kind;
        int depth;
        int n;
        kind = $urandom_range(99);
        if (kind < 60) begin
            // well-formed expression with random content
            depth = 0;
            n = $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(9) == 0)
                    send_symbol(SYM_SPACE);
                if (depth >= 2 && $urandom_range(99) < 45) begin
                    send_symbol(random_op());
                    depth--;
                end else begin
                    send_symbol(random_operand());
                    depth++;
                end
            end
            while (depth > 1 && $urandom_range(3) != 0) begin
                send_symbol(random_op());
                depth--;
            end
            send_symbol(SYM_EQUALS);
        end else if (kind < 66) begin
            // fill the stack up to and past its depth
            n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
            repeat (n) send_symbol(random_operand());
            if ($urandom_range(1))
                send_symbol(random_op());
            if ($urandom_range(1))
                send_symbol(random_operand());
            send_symbol(SYM_EQUALS);
        end else if (kind < 72) begin
            // build 8^10 * 2 = most negative value, then divide by -1
            send_symbol(SYM_ZERO + 8'd8);
            repeat (10) begin
                send_symbol(n == 9 ? SYM_ZERO + 8'd2 : SYM_ZERO + 8'd8);
                send_symbol(SYM_TIMES);
                n++;
            end
            send_symbol(SYM_ZERO);
            send_symbol(SYM_ZERO + 8'd1);
            send_symbol(SYM_MINUS);
            send_symbol(SYM_DIVIDE);
            send_symbol(SYM_EQUALS);
        end else if (kind < 86) begin
            // broken sequences: operators and equals signs on a shallow stack
            n = $urandom_range(1, 6);
            repeat (n) begin
                case ($urandom_range(3))
                    0:       send_symbol(random_op());
                    1:       send_symbol(SYM_EQUALS);
                    2:       send_symbol(SYM_SPACE);
                    default: send_symbol(random_operand());
                endcase
            end
            if ($urandom_range(1))
                send_symbol(SYM_EQUALS);
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) send_symbol(8'($urandom_range(255)));
            if ($urandom_range(1))
                send_symbol(SYM_EQUALS);
        end
    endtask

    initial begin
        logic [7:0] opening [$];
        int         phase_end;
        opening = '{SYM_EQUALS,
                    SYM_ZERO + 8'd9, SYM_ZERO + 8'd3, SYM_MINUS, SYM_ZERO + 8'd4,
                    SYM_TIMES, SYM_ZERO + 8'd7, SYM_DIVIDE, SYM_EQUALS,
                    8'h00, 8'hFF, SYM_SPACE, SYM_PLUS, SYM_EQUALS,
                    SYM_ZERO + 8'd5, SYM_ZERO, SYM_DIVIDE, SYM_ZERO + 8'd3, SYM_EQUALS,
                    SYM_PLUS, SYM_EQUALS,
                    SYM_ZERO + 8'd8, SYM_ZERO + 8'd3, SYM_SPACE, SYM_EQUALS};
        idle_pct      = 0;
        stall_pct     = 0;
        symbols_sent  = 0;
        i_rst_n       = 1'b0;
        sym_ch.valid  = 1'b0;
        sym_ch.symbol = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[k])
            send_symbol(opening[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            phase_end = 25 + (1225 * (phase + 1)) / 4;
            while (symbols_sent < phase_end)
                send_random_sequence();
        end
        sym_ch.valid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("PASS rpn_stack_evaluator");
        else
            $display("FAIL rpn_stack_evaluator");
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_if.sv
sv/rpn_div.sv
sv/rpn_seq.sv
sv/rpn_stack_evaluator.sv
dv/tb_top.sv
